### rtl/dfep_pkg.sv
// Shared types, constants and byte helpers for the FAT directory entry parser.
`default_nettype none

package dfep_pkg;

    localparam int MAX_SEQUENCE_INDEX = 18;
    localparam int LFN_UNITS          = 13;

    // command queue between front and back
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_DEPTH = 1 << CMDQ_AW;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // slot numbering used by the back sequencer
    localparam logic [3:0] SLOT_DOT      = 4'd8;
    localparam logic [3:0] SLOT_EXT      = 4'd9;
    localparam logic [3:0] SLOT_TERM     = 4'd12;
    localparam logic [3:0] SLOT_COMPLETE = 4'd13;

    localparam logic [7:0] BYTE_END     = 8'h00;
    localparam logic [7:0] BYTE_DELETED = 8'hE5;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_DOT     = 8'h2E;
    localparam logic [7:0] BYTE_QMARK   = 8'h3F;
    localparam logic [3:0] ATTR_LFN     = 4'hF;
    localparam int         ATTR_DIR_BIT = 4;
    localparam int         SEQ_FIRST_BIT = 6;

    typedef enum logic [2:0] {
        KIND_CHAR     = 3'd0,
        KIND_COMPLETE = 3'd1,
        KIND_END      = 3'd2,
        KIND_SEQ_ERR  = 3'd3,
        KIND_SKIPPED  = 3'd4
    } res_kind_t;

    typedef enum logic [2:0] {
        OP_END   = 3'd0,
        OP_SKIP  = 3'd1,
        OP_ERR   = 3'd2,
        OP_LFN   = 3'd3,
        OP_SHORT = 3'd4
    } cmd_op_t;

    typedef struct packed {
        logic [63:0] entry_word3;
        logic [63:0] entry_word2;
        logic [63:0] entry_word1;
        logic [63:0] entry_word0;
    } entry_t;

    typedef struct packed {
        res_kind_t   kind;
        logic [7:0]  char_pos;
        logic [7:0]  char_value;
        logic        is_dir;
        logic [31:0] first_cluster;
        logic [31:0] file_size;
        logic [4:0]  seq_index;
        logic        last;
    } result_t;

    typedef struct packed {
        cmd_op_t    op;
        entry_t     entry;
        logic [4:0] seq;
        logic [3:0] start_slot;
        logic [3:0] name_len;
        logic       has_dot;
        logic [1:0] ext_len;
        logic [7:0] lfn_base;
        logic [7:0] term_pos;
    } cmd_t;

    function automatic logic [7:0] entry_byte(input entry_t e, input logic [4:0] k);
        logic [255:0] flat;
        flat = e;
        return flat[{k, 3'b000} +: 8];
    endfunction

    function automatic logic [15:0] entry_u16(input entry_t e, input logic [4:0] k);
        return {entry_byte(e, k + 5'd1), entry_byte(e, k)};
    endfunction

    // byte offset of each UCS-2 unit inside a long-name entry
    function automatic logic [4:0] unit_offset(input logic [3:0] u);
        logic [4:0] off;
        case (u)
            4'd0:    off = 5'd1;
            4'd1:    off = 5'd3;
            4'd2:    off = 5'd5;
            4'd3:    off = 5'd7;
            4'd4:    off = 5'd9;
            4'd5:    off = 5'd14;
            4'd6:    off = 5'd16;
            4'd7:    off = 5'd18;
            4'd8:    off = 5'd20;
            4'd9:    off = 5'd22;
            4'd10:   off = 5'd24;
            4'd11:   off = 5'd28;
            4'd12:   off = 5'd30;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

### rtl/dfep_front.sv
// Front end: classifies each entry, tracks the long-name sequence index.
`default_nettype none

module dfep_front
    import dfep_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   accept,
    input  wire entry_t entry,
    output cmd_t        cmd
);

    logic [4:0] prev_idx_reg;
    logic [4:0] prev_idx_next;

    logic [7:0] b0;
    logic [7:0] attr;
    logic [5:0] idx;
    logic       bad;
    logic [3:0] name_len;
    logic [1:0] ext_len;
    logic [7:0] term_pos;

    always_comb
    begin
        b0   = entry_byte(entry, 5'd0);
        attr = entry_byte(entry, 5'd11);
        idx  = b0[5:0];

        bad = (idx == 6'd0) || (idx > 6'(MAX_SEQUENCE_INDEX));
        if (!bad && !b0[SEQ_FIRST_BIT])
        begin
            bad = (prev_idx_reg == 5'd0) ||
                  ({1'b0, idx} + 7'd1 != {2'b00, prev_idx_reg});
        end

        // first space ends the base name and the extension
        name_len = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            if (entry_byte(entry, 5'(i)) == BYTE_SPACE)
            begin
                name_len = 4'(i);
            end
        end
        ext_len = 2'd3;
        for (int j = 2; j >= 0; j--)
        begin
            if (entry_byte(entry, 5'(8 + j)) == BYTE_SPACE)
            begin
                ext_len = 2'(j);
            end
        end

        term_pos = 8'({2'b00, idx} * 8'(LFN_UNITS));

        cmd            = '0;
        cmd.entry      = entry;
        cmd.name_len   = name_len;
        cmd.has_dot    = (entry_byte(entry, 5'd8) != BYTE_SPACE);
        cmd.ext_len    = ext_len;
        cmd.term_pos   = term_pos;
        cmd.lfn_base   = term_pos - 8'(LFN_UNITS);
        cmd.seq        = idx[4:0];
        cmd.start_slot = SLOT_COMPLETE;
        prev_idx_next  = 5'd0;

        if (b0 == BYTE_END)
        begin
            cmd.op = OP_END;
        end
        else if (b0 == BYTE_DELETED)
        begin
            cmd.op = OP_SKIP;
        end
        else if (attr[3:0] == ATTR_LFN)
        begin
            if (bad)
            begin
                cmd.op = OP_ERR;
            end
            else
            begin
                cmd.op         = OP_LFN;
                cmd.start_slot = b0[SEQ_FIRST_BIT] ? 4'd0 : 4'd1;
                prev_idx_next  = idx[4:0];
            end
        end
        else
        begin
            cmd.op = OP_SHORT;
            // a pending long name replaces the 8.3 name
            cmd.start_slot = (prev_idx_reg == 5'd0) ? 4'd0 : SLOT_COMPLETE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_idx_reg <= 5'd0;
        end
        else if (accept)
        begin
            prev_idx_reg <= prev_idx_next;
        end
    end

endmodule

`default_nettype wire

### rtl/dfep_cmd_queue.sv
// Short command queue between the classifier and the result sequencer.
`default_nettype none

module dfep_cmd_queue
    import dfep_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire cmd_t wr_data,
    output logic      full,
    output logic      empty,
    input  wire logic rd,
    output cmd_t      head
);

    cmd_t                 mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wptr_reg;
    logic [CMDQ_AW-1:0]   rptr_reg;
    logic [CMDQ_CW-1:0]   count_reg;

    assign full  = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr && !full)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd && !empty)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            case ({wr && !full, rd && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/dfep_back.sv
// Back end: walks the head result slots, one per cycle unless stalled.
`default_nettype none

module dfep_back
    import dfep_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head,
    input  wire logic head_valid,
    output logic      head_pop,
    output result_t   result,
    output logic      empty,
    input  wire logic pop
);

    logic       started_reg;
    logic [3:0] slot_reg;
    logic       ended_reg;
    logic [3:0] pos_reg;
    result_t    res_reg;
    logic       res_valid_reg;

    logic       out_ready;
    logic [3:0] eff_slot;
    logic       eff_ended;
    logic [3:0] eff_pos;
    logic       emit;
    logic       is_final;
    logic       advance;
    logic       ended_next;
    logic [3:0] pos_next;
    result_t    res_next;
    logic [15:0] unit;
    logic [7:0]  uchar;
    logic [7:0]  attr;

    assign out_ready = !res_valid_reg || pop;
    assign eff_slot  = started_reg ? slot_reg  : head.start_slot;
    assign eff_ended = started_reg && ended_reg;
    assign eff_pos   = started_reg ? pos_reg   : 4'd0;

    always_comb
    begin
        emit       = 1'b0;
        is_final   = 1'b0;
        ended_next = eff_ended;
        pos_next   = eff_pos;
        res_next   = '0;
        res_next.kind = KIND_CHAR;
        unit  = entry_u16(head.entry, unit_offset(eff_slot - 4'd1));
        uchar = (unit < 16'd127) ? unit[7:0] : BYTE_QMARK;
        attr  = entry_byte(head.entry, 5'd11);

        case (head.op)
            OP_END:
            begin
                emit = 1'b1;
                is_final = 1'b1;
                res_next.kind = KIND_END;
                res_next.last = 1'b1;
            end
            OP_SKIP:
            begin
                emit = 1'b1;
                is_final = 1'b1;
                res_next.kind = KIND_SKIPPED;
                res_next.last = 1'b1;
            end
            OP_ERR:
            begin
                emit = 1'b1;
                is_final = 1'b1;
                res_next.kind = KIND_SEQ_ERR;
                res_next.last = 1'b1;
            end
            OP_LFN:
            begin
                emit = 1'b1;
                res_next.seq_index = head.seq;
                if (eff_slot == 4'd0)
                begin
                    res_next.char_pos = head.term_pos;
                end
                else
                begin
                    res_next.char_pos   = head.lfn_base + {4'b0000, eff_slot - 4'd1};
                    // zero everything after the first NUL unit
                    res_next.char_value = eff_ended ? 8'h00 : uchar;
                    ended_next          = eff_ended || (unit == 16'h0000);
                    is_final            = (eff_slot == 4'(LFN_UNITS));
                    res_next.last       = is_final;
                end
            end
            OP_SHORT:
            begin
                res_next.char_pos = {4'b0000, eff_pos};
                if (eff_slot < SLOT_DOT)
                begin
                    emit = (eff_slot < head.name_len);
                    res_next.char_value = entry_byte(head.entry, {1'b0, eff_slot});
                end
                else if (eff_slot == SLOT_DOT)
                begin
                    emit = head.has_dot;
                    res_next.char_value = BYTE_DOT;
                end
                else if (eff_slot < SLOT_TERM)
                begin
                    emit = (eff_slot < SLOT_EXT + {2'b00, head.ext_len});
                    res_next.char_value = entry_byte(head.entry, {1'b0, eff_slot - 4'd1});
                end
                else if (eff_slot == SLOT_TERM)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                    is_final = 1'b1;
                    res_next.kind          = KIND_COMPLETE;
                    res_next.char_pos      = 8'h00;
                    res_next.is_dir        = attr[ATTR_DIR_BIT];
                    res_next.first_cluster = {entry_u16(head.entry, 5'd20),
                                              entry_u16(head.entry, 5'd26)};
                    res_next.file_size     = {entry_u16(head.entry, 5'd30),
                                              entry_u16(head.entry, 5'd28)};
                    res_next.last          = 1'b1;
                end
                if (emit && !is_final)
                begin
                    pos_next = eff_pos + 4'd1;
                end
            end
            default:
            begin
                // drop an unknown command
                is_final = 1'b1;
            end
        endcase
    end

    assign advance  = head_valid && (!emit || out_ready);
    assign head_pop = advance && is_final;
    assign result   = res_reg;
    assign empty    = !res_valid_reg;

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            slot_reg      <= 4'd0;
            ended_reg     <= 1'b0;
            pos_reg       <= 4'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                started_reg <= !is_final;
                slot_reg    <= eff_slot + 4'd1;
                ended_reg   <= ended_next;
                pos_reg     <= pos_next;
            end
            if (advance && emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/fat_directory_entry_parser_core.sv
// Top level of the FAT directory entry parser with long-name support.
//
// Input channel: a 32-byte directory entry is pushed as four 64-bit words;
// a transaction completes on a clock edge with push high and full low.
// Result channel: the oldest result sits on result while empty is low and
// is taken on an edge with pop high and empty low. Each entry yields 1 to 14
// results, the final one marked by result.last.
// An accepted entry is written to the command queue and its results are
// registered. Throughput: the back sequencer spends one cycle on each result
// slot of the head entry of the command queue unless the receiver stalls:
// one slot for an end, deleted, error or short entry after a long name, 13
// or 14 for a long-name entry, 14 for a short entry with its 8.3 name.
// A two-deep command queue lets new entries come in while results drain.
// When the receiver stalls the result register holds, the sequencer stops at
// its next result, and full rises once the command queue fills.
// Reset clears the long-name sequence index, the queue and the result stage.
`default_nettype none

module fat_directory_entry_parser_core
    import dfep_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    output logic        full,
    input  wire entry_t entry,
    output logic        empty,
    input  wire logic   pop,
    output result_t     result
);

    cmd_t cmd;
    cmd_t head;
    logic accept;
    logic q_empty;
    logic head_pop;

    assign accept = push && !full;

    dfep_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .entry  (entry),
        .cmd    (cmd)
    );

    dfep_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (accept),
        .wr_data (cmd),
        .full    (full),
        .empty   (q_empty),
        .rd      (head_pop),
        .head    (head)
    );

    dfep_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_empty),
        .head_pop   (head_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

`ifndef SYNTHESIS
    // every result other than a name char closes its entry
    a_nonchar_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_CHAR) |-> result.last)
        else $error("non-char result without last");

    // only completion records carry entry metadata
    a_meta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_COMPLETE) |->
        (!result.is_dir && result.first_cluster == 32'd0 && result.file_size == 32'd0))
        else $error("metadata on non-completion result");

    // 8.3 name characters stay within the short-name buffer
    a_short_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_CHAR && result.seq_index == 5'd0) |->
        (result.char_pos < 8'd13))
        else $error("short name position out of range");
`endif

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for the FAT directory entry parser: random and directed entries.
module tb;
    import dfep_pkg::*;

    localparam int ITEM_TARGET  = 210;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    class entry_scoreboard;
        result_t    parse_results_due[$];
        logic [4:0] lfn_index;
        int         errors;
        int         checked;
        int         n_lfn;
        int         n_short;
        int         n_end;
        int         n_skip;
        int         n_seq_err;

        function new();
            lfn_index = '0;
            errors    = 0;
            checked   = 0;
            n_lfn     = 0;
            n_short   = 0;
            n_end     = 0;
            n_skip    = 0;
            n_seq_err = 0;
        endfunction

        // byte offset of each UCS-2 unit in a long-name entry
        static function int unit_offset_of(int u);
            int offs [13];
            offs = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};
            return offs[u];
        endfunction

        function void queue_result(res_kind_t kind, logic [7:0] pos, logic [7:0] val,
                                   logic dir, logic [31:0] clus, logic [31:0] size,
                                   logic [4:0] seq);
            result_t r;
            r.kind          = kind;
            r.char_pos      = pos;
            r.char_value    = val;
            r.is_dir        = dir;
            r.first_cluster = clus;
            r.file_size     = size;
            r.seq_index     = seq;
            r.last          = 1'b0;
            parse_results_due.push_back(r);
        endfunction

        function void note_entry(entry_t e);
            logic [255:0] raw;
            logic [7:0]   b0;
            logic [7:0]   attr;
            logic [7:0]   c;
            logic [15:0]  u;
            logic [31:0]  clus;
            logic [31:0]  size;
            int           ord;
            int           base;
            int           pos;
            bit           bad;
            bit           ended;
            bit           stop;
            result_t      tail;

            raw  = e;
            b0   = raw[7:0];
            attr = raw[95:88];
            if (b0 == BYTE_END) begin
                queue_result(KIND_END, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0, 5'd0);
                lfn_index = '0;
                n_end++;
            end else if (b0 == BYTE_DELETED) begin
                queue_result(KIND_SKIPPED, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0, 5'd0);
                lfn_index = '0;
                n_skip++;
            end else if (attr[3:0] == ATTR_LFN) begin
                ord = int'(b0[5:0]);
                bad = (ord == 0) || (ord > MAX_SEQUENCE_INDEX);
                // a continuation entry must be exactly one below the last one
                if (!bad && !b0[SEQ_FIRST_BIT])
                    bad = (lfn_index == 0) || (ord + 1 != int'(lfn_index));
                if (bad) begin
                    queue_result(KIND_SEQ_ERR, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0, 5'd0);
                    lfn_index = '0;
                    n_seq_err++;
                end else begin
                    base  = (ord - 1) * LFN_UNITS;
                    ended = 1'b0;
                    if (b0[SEQ_FIRST_BIT])
                        queue_result(KIND_CHAR, 8'(ord * LFN_UNITS), 8'h00, 1'b0,
                                     32'h0, 32'h0, 5'(ord));
                    for (int k = 0; k < LFN_UNITS; k++) begin
                        u = raw[8 * unit_offset_of(k) +: 16];
                        c = (u < 16'd127) ? u[7:0] : BYTE_QMARK;
                        if (ended)
                            c = 8'h00;
                        else if (c == 8'h00)
                            ended = 1'b1;
                        queue_result(KIND_CHAR, 8'(base + k), c, 1'b0, 32'h0, 32'h0,
                                     5'(ord));
                    end
                    lfn_index = 5'(ord);
                    n_lfn++;
                end
            end else begin
                clus = {raw[8 * 20 +: 16], raw[8 * 26 +: 16]};
                size = raw[8 * 28 +: 32];
                if (lfn_index == 0) begin
                    pos  = 0;
                    stop = 1'b0;
                    for (int k = 0; k < 8; k++) begin
                        c = raw[8 * k +: 8];
                        if (c == BYTE_SPACE)
                            stop = 1'b1;
                        if (!stop) begin
                            queue_result(KIND_CHAR, 8'(pos), c, 1'b0, 32'h0, 32'h0, 5'd0);
                            pos++;
                        end
                    end
                    if (raw[71:64] != BYTE_SPACE) begin
                        queue_result(KIND_CHAR, 8'(pos), BYTE_DOT, 1'b0, 32'h0, 32'h0, 5'd0);
                        pos++;
                    end
                    stop = 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        c = raw[8 * (8 + k) +: 8];
                        if (c == BYTE_SPACE)
                            stop = 1'b1;
                        if (!stop) begin
                            queue_result(KIND_CHAR, 8'(pos), c, 1'b0, 32'h0, 32'h0, 5'd0);
                            pos++;
                        end
                    end
                    queue_result(KIND_CHAR, 8'(pos), 8'h00, 1'b0, 32'h0, 32'h0, 5'd0);
                end
                queue_result(KIND_COMPLETE, 8'h00, 8'h00, attr[ATTR_DIR_BIT], clus, size,
                             5'd0);
                lfn_index = '0;
                n_short++;
            end
            tail = parse_results_due.pop_back();
            tail.last = 1'b1;
            parse_results_due.push_back(tail);
        endfunction

        function void report(string why, result_t want, result_t got);
            errors++;
            if (errors <= 10) begin
                $display("ERROR %s", why);
                $display("  exp kind=%0d pos=%0d val=%h dir=%0d clus=%h size=%h seq=%0d last=%0d",
                         want.kind, want.char_pos, want.char_value, want.is_dir,
                         want.first_cluster, want.file_size, want.seq_index, want.last);
                $display("  got kind=%0d pos=%0d val=%h dir=%0d clus=%h size=%h seq=%0d last=%0d",
                         got.kind, got.char_pos, got.char_value, got.is_dir,
                         got.first_cluster, got.file_size, got.seq_index, got.last);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit      bad;
            if (parse_results_due.size() == 0) begin
                report("result with nothing outstanding", '0, got);
            end else begin
                want = parse_results_due.pop_front();
                checked++;
                bad = (got.kind !== want.kind) || (got.char_pos !== want.char_pos)
                   || (got.char_value !== want.char_value) || (got.is_dir !== want.is_dir)
                   || (got.first_cluster !== want.first_cluster)
                   || (got.file_size !== want.file_size)
                   || (got.seq_index !== want.seq_index) || (got.last !== want.last);
                if (bad)
                    report("result mismatch", want, got);
            end
        endfunction

        function int pending();
            return parse_results_due.size();
        endfunction

        function void close_out();
            if (parse_results_due.size() != 0) begin
                errors += parse_results_due.size();
                $display("ERROR %0d expected results never arrived", parse_results_due.size());
            end
        endfunction
    endclass

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    entry_t  entry = '0;
    logic    full;
    logic    empty;
    result_t result;

    entry_scoreboard sb = new();
    int cycle_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;

    fat_directory_entry_parser_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .entry  (entry),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb failed");
        $finish;
    end

    function automatic logic [255:0] random_raw();
        logic [255:0] raw;
        for (int i = 0; i < 8; i++)
            raw[32 * i +: 32] = $urandom;
        return raw;
    endfunction

    function automatic logic [15:0] random_unit();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(127, 255));
            2:       return 16'd126;
            3:       return 16'd127;
            4:       return 16'hFFFF;
            default: return 16'($urandom_range(32, 126));
        endcase
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == BYTE_SPACE || c == BYTE_DELETED);
        return c;
    endfunction

    // long-name entry; unit nul_at is NUL, later units stay random (13 = full name)
    function automatic entry_t lfn_entry(logic [7:0] ord, int nul_at);
        logic [255:0] raw;
        int           off;
        raw        = random_raw();
        raw[7:0]   = ord;
        raw[95:88] = {4'($urandom), ATTR_LFN};
        for (int u = 0; u < LFN_UNITS; u++) begin
            off = entry_scoreboard::unit_offset_of(u);
            if (u < nul_at)
                raw[8 * off +: 16] = random_unit();
            else if (u == nul_at)
                raw[8 * off +: 16] = 16'h0000;
        end
        return entry_t'(raw);
    endfunction

    function automatic entry_t short_entry(logic dir, int name_len, int ext_len);
        logic [255:0] raw;
        logic [7:0]   attr;
        raw = random_raw();
        for (int k = 0; k < 8; k++) begin
            if (k < name_len)
                raw[8 * k +: 8] = name_byte();
            else if (k == name_len)
                raw[8 * k +: 8] = BYTE_SPACE;
        end
        for (int k = 0; k < 3; k++) begin
            if (k < ext_len)
                raw[8 * (8 + k) +: 8] = name_byte();
            else if (k == ext_len)
                raw[8 * (8 + k) +: 8] = BYTE_SPACE;
        end
        attr = 8'($urandom);
        if (attr[3:0] == ATTR_LFN)
            attr[0] = 1'b0;
        attr[ATTR_DIR_BIT] = dir;
        raw[95:88] = attr;
        return entry_t'(raw);
    endfunction

    task automatic send(entry_t e);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        push  <= 1'b1;
        entry <= e;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_entry(e);
        burst_left--;
        items_sent++;
    endtask

    // stop sending until every predicted result has been taken
    task automatic hold_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // ord bytes n..1 (first one flagged), dropping index drop, then the short entry
    task automatic send_name_chain(int n, int drop);
        logic [7:0] ord;
        int         nul_at;
        for (int i = n; i >= 1; i--) begin
            if (i != drop) begin
                ord = {1'($urandom_range(0, 7) == 0), 1'(i == n), 6'(i)};
                if (i == n || $urandom_range(0, 5) == 0)
                    nul_at = $urandom_range(0, 13);
                else
                    nul_at = 13;
                send(lfn_entry(ord, nul_at));
            end
        end
        send(short_entry(1'($urandom), $urandom_range(0, 8), $urandom_range(0, 3)));
    endtask

    initial begin
        int mode;
        int phase_left;
        int hold;
        mode       = 0;
        phase_left = 0;
        hold       = 0;
        while (!rst_n)
            @(posedge clk);
        forever begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(result);
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            case (mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 7) == 0);
                default:
                begin
                    if (hold > 0) begin
                        pop <= 1'b0;
                        hold--;
                    end else begin
                        pop <= 1'b1;
                        if ($urandom_range(0, 9) == 0)
                            hold = $urandom_range(5, 20);
                    end
                end
            endcase
        end
    end

    initial begin
        entry_t       e;
        logic [255:0] raw;
        int           pick;
        int           n;
        bit           paused;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send('0);
        send('1);
        raw      = random_raw();
        raw[7:0] = BYTE_DELETED;
        send(entry_t'(raw));
        send(short_entry(1'b0, 8, 3));
        e = short_entry(1'b1, 1, 0);
        e.entry_word2[47:32] = 16'hFFFF;
        e.entry_word3[63:16] = '1;
        send(e);
        send(short_entry(1'b0, 0, 3));
        // two-part long name followed by its short entry
        send(lfn_entry(8'h42, 13));
        send(lfn_entry(8'h01, 13));
        send(short_entry(1'b0, 8, 3));
        e = lfn_entry(8'h41, 13);
        e.entry_word0[23:8]  = 16'd126;
        e.entry_word0[39:24] = 16'd127;
        e.entry_word0[55:40] = 16'hFFFF;
        send(e);
        send(short_entry(1'b1, 4, 2));
        send(lfn_entry(8'h41, 0));
        send(short_entry(1'b0, 3, 3));
        send(lfn_entry(8'h40 | 8'(MAX_SEQUENCE_INDEX), 5));
        send(short_entry(1'b0, 2, 1));
        // bad indexes and broken order
        send(lfn_entry(8'h40, 13));
        send(lfn_entry(8'h40 | 8'(MAX_SEQUENCE_INDEX + 1), 13));
        send(lfn_entry(8'h05, 13));
        send(lfn_entry(8'h43, 13));
        send(lfn_entry(8'h01, 13));
        send(lfn_entry(8'h42, 13));
        raw      = random_raw();
        raw[7:0] = BYTE_END;
        send(entry_t'(raw));
        send(lfn_entry(8'h01, 13));
        send(lfn_entry(8'h42, 13));
        raw      = random_raw();
        raw[7:0] = BYTE_DELETED;
        send(entry_t'(raw));
        hold_until_drained();

        paused = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_SEQUENCE_INDEX)
                                                : $urandom_range(1, 4);
                send_name_chain(n, 0);
            end else if (pick < 70) begin
                send(short_entry(1'($urandom), $urandom_range(0, 8), $urandom_range(0, 3)));
            end else if (pick < 78) begin
                n = $urandom_range(2, 5);
                send_name_chain(n, $urandom_range(1, n));
            end else if (pick < 88) begin
                send(entry_t'(random_raw()));
            end else if (pick < 92) begin
                raw      = random_raw();
                raw[7:0] = BYTE_END;
                send(entry_t'(raw));
            end else if (pick < 95) begin
                raw      = random_raw();
                raw[7:0] = BYTE_DELETED;
                send(entry_t'(raw));
            end else begin
                send(lfn_entry(8'($urandom_range(1, 127)), $urandom_range(0, 13)));
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();
        $display("covered %0d entries: %0d long-name, %0d short, %0d end, %0d deleted",
                 items_sent, sb.n_lfn, sb.n_short, sb.n_end, sb.n_skip);
        $display("rejected %0d out-of-order or bad-index entries, checked %0d results",
                 sb.n_seq_err, sb.checked);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### fat_directory_entry_parser_core.f
rtl/dfep_pkg.sv
rtl/dfep_front.sv
rtl/dfep_cmd_queue.sv
rtl/dfep_back.sv
rtl/fat_directory_entry_parser_core.sv
bench/tb.sv
